@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, quiet while rst_ni is low
`define BGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define BGR_ASSERT_IMP(lbl, ante, cons, msg) \
  `BGR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/bgr_pkg.sv @@
package bgr_pkg;

  localparam int unsigned BITMAP_BYTES_DEF = 8192;
  localparam int unsigned MAX_ROWS_DEF     = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;
  // hard cap on rows per character
  localparam int unsigned ROW_CAP          = 32;
  localparam int unsigned ADDR_W_MAX       = 16;
  localparam int unsigned MASK_W           = 15;

  // reset values of the configuration registers
  localparam logic [5:0] GLYPH_ROWS_RST    = 6'd8;
  localparam logic [7:0] ROW_STRIDE_RST    = 8'd1;
  localparam logic [5:0] SPACE_ADV_RST     = 6'd2;
  localparam logic [5:0] CHAR_GAP_RST      = 6'd0;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_DRAW    = 2'd1,
    CMD_WR_DESC = 2'd2,
    CMD_WR_BMP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_GLYPH_ROWS = 2'd0,
    CFG_ROW_STRIDE = 2'd1,
    CFG_SPACE_ADV  = 2'd2,
    CFG_CHAR_GAP   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DESC = 2'd1,
    ST_ROWS = 2'd2
  } back_state_e;

  // classified command; addr is already wrapped for the target store
  typedef struct packed {
    cmd_e                  cmd;
    logic [9:0]            x_pos;
    logic [7:0]            y_pos;
    logic [7:0]            ink;
    logic [7:0]            char_code;
    logic [ADDR_W_MAX-1:0] addr;
    logic [15:0]           data;
  } cmd_t;

  typedef struct packed {
    logic [5:0] glyph_rows;
    logic [7:0] row_stride;
    logic [5:0] space_advance;
    logic [5:0] char_gap;
  } cfg_t;

endpackage

@@ hw/rtl/bitmap_glyph_row_rasterizer.sv @@
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid / s_axis_tready tdata: x_pos, y_pos, ink_color, char_code,
//                                              table_address, table_data; tuser: command
// m_axis    out  m_axis_tvalid / m_axis_tready tdata: pixel_row, pixel_x, row_mask,
//                                              paint_color, next_x; tlast: last_row
// cfg       in   cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// start and table writes finish as they are popped in the back end; a draw holds it for
// its pop, its descriptor read, then its rows: glyph_rows clamped to 1..min(MAX_ROWS, 32),
// or one for zero width, at one row a cycle unless m_axis stalls
// row rate is set by the bitmap in three copies: three bytes of a row per unstalled cycle
// after issue a row passes the bitmap read register, then the output register
// tables have no reset and need no clearing pass; pen and config registers reset at once
// a stalled m_axis freezes only the row pipeline; front register and a two-entry queue
// keep taking items until they are full

module bitmap_glyph_row_rasterizer import bgr_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF,
  parameter int unsigned MAX_ROWS     = MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_pos[9:0], y_pos[17:10], ink_color[25:18], char_code[33:26],
  // table_address[46:34], table_data[62:47], zero[63]
  input  logic [63:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_row[7:0], pixel_x[17:8], row_mask[32:18], paint_color[40:33],
  // next_x[50:41], zero[55:51]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t              cfg_q;
  logic              push_valid, push_ready;
  cmd_t              push_item;
  logic              pop_valid, pop_ready;
  cmd_t              pop_item;
  logic [7:0]        out_row;
  logic [9:0]        out_x;
  logic [MASK_W-1:0] out_mask;
  logic [7:0]        out_color;
  logic [9:0]        out_next_x;

  // config writes land unchecked; the host must write only while the block is idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_rows    <= GLYPH_ROWS_RST;
      cfg_q.row_stride    <= ROW_STRIDE_RST;
      cfg_q.space_advance <= SPACE_ADV_RST;
      cfg_q.char_gap      <= CHAR_GAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GLYPH_ROWS: cfg_q.glyph_rows    <= cfg_data_i[5:0];
        CFG_ROW_STRIDE: cfg_q.row_stride    <= cfg_data_i;
        CFG_SPACE_ADV:  cfg_q.space_advance <= cfg_data_i[5:0];
        CFG_CHAR_GAP:   cfg_q.char_gap      <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // front: takes items, wraps table addresses
  bgr_front #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  // short queue decoupling the front from the row engine
  bgr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  // back: tables, pen state and the row pipeline
  bgr_back #(
    .BITMAP_BYTES(BITMAP_BYTES),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_x_o     (out_x),
    .out_mask_o  (out_mask),
    .out_color_o (out_color),
    .out_next_x_o(out_next_x),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_next_x, out_color, out_mask, out_x, out_row};

endmodule

@@ hw/rtl/bgr_front.sv @@
`include "assert_macros.svh"

module bgr_front import bgr_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_cmd_i,
  input  logic [63:0] in_data_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output cmd_t        push_item_o
);

  // 13-bit address against a memory of at least 256 bytes: four halvings suffice
  localparam int WRAP_SHIFT = 4;

  logic        valid_q;
  cmd_t        item_q;
  cmd_t        item_d;
  logic [12:0] bmp_addr;

  always_comb begin
    logic [12:0] v;
    v = in_data_i[46:34];
    for (int k = WRAP_SHIFT; k >= 0; k--) begin
      if (32'(v) >= (32'(BITMAP_BYTES) << k)) begin
        v = v - 13'(32'(BITMAP_BYTES) << k);
      end
    end
    bmp_addr = v;
  end

  always_comb begin
    item_d.cmd       = cmd_e'(in_cmd_i);
    item_d.x_pos     = in_data_i[9:0];
    item_d.y_pos     = in_data_i[17:10];
    item_d.ink       = in_data_i[25:18];
    item_d.char_code = in_data_i[33:26];
    item_d.data      = in_data_i[62:47];
    if (item_d.cmd == CMD_WR_DESC) begin
      item_d.addr = ADDR_W_MAX'(in_data_i[41:34]);
    end else begin
      item_d.addr = ADDR_W_MAX'(bmp_addr);
    end
  end

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  `BGR_ASSERT_IMP(a_front_bmp_wrap, valid_q && item_q.cmd == CMD_WR_BMP, 32'(item_q.addr) < 32'(BITMAP_BYTES), "bitmap write address not wrapped")

endmodule

@@ hw/rtl/bgr_queue.sv @@
`include "assert_macros.svh"

module bgr_queue import bgr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_item_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  `BGR_ASSERT_IMP(a_queue_ptr_cnt, wr_ptr_q == rd_ptr_q, cnt_q == '0 || cnt_q == CW'(DEPTH), "queue pointers disagree with count")

endmodule

@@ hw/rtl/bgr_back.sv @@
`include "assert_macros.svh"

module bgr_back import bgr_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF,
  parameter int unsigned MAX_ROWS     = MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  cmd_t              pop_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_row_o,
  output logic [9:0]        out_x_o,
  output logic [MASK_W-1:0] out_mask_o,
  output logic [7:0]        out_color_o,
  output logic [9:0]        out_next_x_o,
  output logic              out_last_o
);

  localparam int AW      = $clog2(BITMAP_BYTES);
  localparam int RIW     = $clog2(ROW_CAP);
  localparam int ROW_LIM = (MAX_ROWS < ROW_CAP) ? MAX_ROWS : ROW_CAP;

  // descriptor table and three copies of the bitmap, one per byte of a row window
  logic [15:0] desc_mem [256];
  logic [7:0]  bmp0_mem [BITMAP_BYTES];
  logic [7:0]  bmp1_mem [BITMAP_BYTES];
  logic [7:0]  bmp2_mem [BITMAP_BYTES];

  back_state_e state_q, state_d;

  logic [15:0]     desc_rd_q;
  logic [9:0]      pen_x_q;
  logic [7:0]      pen_y_q;
  logic [7:0]      pen_color_q;

  // per-character sequencer state
  logic [AW-1:0]   base_q;
  logic [2:0]      sel_q;
  logic [3:0]      width_q;
  logic [5:0]      rows_q;
  logic [RIW-1:0]  row_q;
  logic [9:0]      nx_q;
  logic [9:0]      cur_x_q;

  // read stage
  logic            p1_valid_q;
  logic [7:0]      b0_q, b1_q, b2_q;
  logic [7:0]      p1_row_q;
  logic [9:0]      p1_x_q;
  logic [7:0]      p1_color_q;
  logic [9:0]      p1_nx_q;
  logic            p1_last_q;
  logic [3:0]      p1_width_q;
  logic [2:0]      p1_sel_q;

  // output register
  logic              out_valid_q;
  logic [7:0]        out_row_q;
  logic [9:0]        out_x_q;
  logic [MASK_W-1:0] out_mask_q;
  logic [7:0]        out_color_q;
  logic [9:0]        out_nx_q;
  logic              out_last_q;

  logic            en;
  logic            popping;
  logic            desc_re, desc_we, bmp_we, start;
  logic            issue;
  logic            row_last;
  logic [3:0]      width;
  logic            zero_w;
  logic [5:0]      adv;
  logic [9:0]      nx;
  logic [5:0]      rows_eff;
  logic [AW:0]     sum1, sum2, sum_next;
  logic [AW-1:0]   a1, a2, base_next;
  logic [23:0]     window;
  logic [MASK_W-1:0] raw_mask, width_mask, mask;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = state_q == ST_IDLE;
  assign popping     = pop_valid_i && pop_ready_o;
  assign desc_re     = popping && pop_item_i.cmd == CMD_DRAW;
  assign desc_we     = popping && pop_item_i.cmd == CMD_WR_DESC;
  assign bmp_we      = popping && pop_item_i.cmd == CMD_WR_BMP;
  assign start       = popping && pop_item_i.cmd == CMD_START;
  assign issue       = state_q == ST_ROWS && en;
  assign row_last    = 6'(row_q) + 6'd1 == rows_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (desc_re) state_d = ST_DESC;
      end
      ST_DESC: state_d = ST_ROWS;
      ST_ROWS: begin
        if (issue && row_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // descriptor decode
  always_comb begin
    width  = desc_rd_q[7:4];
    zero_w = width == 4'd0;
    adv    = zero_w ? cfg_i.space_advance : 6'(width);
    nx     = pen_x_q + 10'(adv) + 10'(cfg_i.char_gap);
    if (zero_w || cfg_i.glyph_rows == 6'd0) begin
      rows_eff = 6'd1;
    end else if (32'(cfg_i.glyph_rows) > 32'(ROW_LIM)) begin
      rows_eff = 6'(ROW_LIM);
    end else begin
      rows_eff = cfg_i.glyph_rows;
    end
  end

  // row window addresses, wrapped at the end of the bitmap
  always_comb begin
    sum1 = {1'b0, base_q} + (AW+1)'(1);
    a1   = (sum1 >= (AW+1)'(BITMAP_BYTES)) ? AW'(sum1 - (AW+1)'(BITMAP_BYTES)) : AW'(sum1);
    sum2 = {1'b0, a1} + (AW+1)'(1);
    a2   = (sum2 >= (AW+1)'(BITMAP_BYTES)) ? AW'(sum2 - (AW+1)'(BITMAP_BYTES)) : AW'(sum2);
    sum_next  = {1'b0, base_q} + (AW+1)'(cfg_i.row_stride);
    base_next = (sum_next >= (AW+1)'(BITMAP_BYTES)) ?
                AW'(sum_next - (AW+1)'(BITMAP_BYTES)) : AW'(sum_next);
  end

  // msb-first bits into an lsb-first mask
  always_comb begin
    window = {b0_q, b1_q, b2_q} << p1_sel_q;
    for (int n = 0; n < MASK_W; n++) begin
      raw_mask[n] = window[23 - n];
    end
    width_mask = MASK_W'((16'd1 << p1_width_q) - 16'd1);
    mask       = raw_mask & width_mask;
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) desc_mem[pop_item_i.addr[7:0]] <= pop_item_i.data;
    if (desc_re) desc_rd_q <= desc_mem[pop_item_i.char_code];
    if (bmp_we) begin
      bmp0_mem[pop_item_i.addr[AW-1:0]] <= pop_item_i.data[7:0];
      bmp1_mem[pop_item_i.addr[AW-1:0]] <= pop_item_i.data[7:0];
      bmp2_mem[pop_item_i.addr[AW-1:0]] <= pop_item_i.data[7:0];
    end
    if (issue) begin
      b0_q <= bmp0_mem[base_q];
      b1_q <= bmp1_mem[a1];
      b2_q <= bmp2_mem[a2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      pen_color_q <= '0;
    end else if (start) begin
      pen_x_q     <= pop_item_i.x_pos;
      pen_y_q     <= pop_item_i.y_pos;
      pen_color_q <= pop_item_i.ink;
    end else if (state_q == ST_DESC) begin
      pen_x_q     <= nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DESC) begin
      base_q  <= AW'(desc_rd_q[11:3]);
      sel_q   <= desc_rd_q[2:0];
      width_q <= width;
      rows_q  <= rows_eff;
      row_q   <= '0;
      nx_q    <= nx;
      cur_x_q <= pen_x_q;
    end else if (issue) begin
      base_q  <= base_next;
      row_q   <= row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q  <= issue;
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_row_q   <= pen_y_q + 8'(row_q);
      p1_x_q     <= cur_x_q;
      p1_color_q <= pen_color_q;
      p1_nx_q    <= nx_q;
      p1_last_q  <= row_last;
      p1_width_q <= width_q;
      p1_sel_q   <= sel_q;
    end
    if (en && p1_valid_q) begin
      out_row_q   <= p1_row_q;
      out_x_q     <= p1_x_q;
      out_mask_q  <= mask;
      out_color_q <= p1_color_q;
      out_nx_q    <= p1_nx_q;
      out_last_q  <= p1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_x_o      = out_x_q;
  assign out_mask_o   = out_mask_q;
  assign out_color_o  = out_color_q;
  assign out_next_x_o = out_nx_q;
  assign out_last_o   = out_last_q;

  `BGR_ASSERT_IMP(a_back_row_range, state_q == ST_ROWS, 6'(row_q) < rows_q, "row counter past row count")
  `BGR_ASSERT(a_back_last_idle, issue && row_last |=> state_q == ST_IDLE, "sequencer kept running after last row")

endmodule
